FILE: hw/rtl/pst_pkg.sv
// Shared types, register indexes and helpers for the particle state update pipeline.
// No dependencies; every other file imports this package.
package pst_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Z   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_COLOR   = 3'd4;

  localparam logic [31:0] GRAVITY_X_RST   = 32'h0000_0000;
  localparam logic [31:0] GRAVITY_Y_RST   = 32'hFFFE_0000;
  localparam logic [31:0] GRAVITY_Z_RST   = 32'h0000_0000;
  localparam logic [31:0] START_COLOR_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] END_COLOR_RST   = 32'hFFFF_FF00;

  // Number of quotient bits of the blend factor, one per divider stage.
  localparam int DIV_STAGES = 16;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] spin_angle;
    logic signed [31:0] spin_rate;
    logic signed [23:0] life_left;
    logic [22:0]        life_total;
    logic [15:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic signed [31:0] new_vel_z;
    logic signed [31:0] new_spin_angle;
    logic [22:0]        new_life_left;
    logic [7:0]         color_red;
    logic [7:0]         color_green;
    logic [7:0]         color_blue;
    logic [7:0]         color_alpha;
  } out_word_t;

  // Motion results handed from the motion unit to the output alignment line.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] angle;
    logic [22:0]        life;
  } motion_t;

  // Adds a Q16.16 value and a floored product (product >>> 16) and clamps to 32 bits.
  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [48:0] prod);
    logic signed [33:0] sum;
    begin
      sum = {{2{a[31]}}, a} + {prod[48], prod[48:16]};
      if (sum > 34'sh0_7FFF_FFFF) begin
        add_sat = 32'sh7FFF_FFFF;
      end else if (sum < -34'sh0_8000_0000) begin
        add_sat = 32'sh8000_0000;
      end else begin
        add_sat = sum[31:0];
      end
    end
  endfunction

endpackage

FILE: hw/rtl/pst_motion.sv
// Four-stage motion unit: velocity and rotation from gravity and spin rate, then position from velocity.
// Depends on pst_pkg.
module pst_motion
  import pst_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       gravity_x,
  input  logic [31:0]       gravity_y,
  input  logic [31:0]       gravity_z,
  input  in_word_t          rec,
  input  logic [22:0]       life,
  output motion_t           res
);

  logic signed [48:0] gprod [3];
  logic signed [48:0] rprod;
  logic signed [31:0] pos1 [3];
  logic signed [31:0] vel1 [3];
  logic signed [31:0] ang1;
  logic [15:0]        dt1;
  logic [22:0]        life1;

  logic signed [31:0] pos2 [3];
  logic signed [31:0] vel2 [3];
  logic signed [31:0] ang2;
  logic [15:0]        dt2;
  logic [22:0]        life2;

  logic signed [48:0] vprod [3];
  logic signed [31:0] pos3 [3];
  logic signed [31:0] vel3 [3];
  logic signed [31:0] ang3;
  logic [22:0]        life3;

  logic signed [48:0] dt_s;
  logic signed [48:0] dt2_s;

  function automatic logic signed [48:0] sx49(input logic [31:0] v);
    return $signed({{17{v[31]}}, v});
  endfunction

  assign dt_s  = $signed({33'd0, rec.time_step});
  assign dt2_s = $signed({33'd0, dt2});

  always_ff @(posedge clk) begin
    if (en) begin
      // Stage 1: gravity and spin products.
      gprod[0] <= sx49(gravity_x) * dt_s;
      gprod[1] <= sx49(gravity_y) * dt_s;
      gprod[2] <= sx49(gravity_z) * dt_s;
      rprod    <= sx49(rec.spin_rate) * dt_s;
      pos1[0]  <= rec.pos_x;
      pos1[1]  <= rec.pos_y;
      pos1[2]  <= rec.pos_z;
      vel1[0]  <= rec.vel_x;
      vel1[1]  <= rec.vel_y;
      vel1[2]  <= rec.vel_z;
      ang1     <= rec.spin_angle;
      dt1      <= rec.time_step;
      life1    <= life;
      // Stage 2: new velocity and angle.
      for (int i = 0; i < 3; i++) begin
        vel2[i] <= add_sat(vel1[i], gprod[i]);
        pos2[i] <= pos1[i];
      end
      ang2  <= add_sat(ang1, rprod);
      dt2   <= dt1;
      life2 <= life1;
      // Stage 3: velocity products.
      for (int i = 0; i < 3; i++) begin
        vprod[i] <= sx49(vel2[i]) * dt2_s;
        pos3[i]  <= pos2[i];
        vel3[i]  <= vel2[i];
      end
      ang3  <= ang2;
      life3 <= life2;
      // Stage 4: new position.
      res.pos_x <= add_sat(pos3[0], vprod[0]);
      res.pos_y <= add_sat(pos3[1], vprod[1]);
      res.pos_z <= add_sat(pos3[2], vprod[2]);
      res.vel_x <= vel3[0];
      res.vel_y <= vel3[1];
      res.vel_z <= vel3[2];
      res.angle <= ang3;
      res.life  <= life3;
    end
  end

endmodule

FILE: hw/rtl/pst_div.sv
// Pipelined restoring divider giving the 16-bit fractional blend factor, one bit per stage.
// Depends on pst_pkg; the dividend must be below the divisor.
module pst_div
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [22:0] num,
  input  logic [22:0] den,
  output logic [15:0] quo
);

  logic [22:0] rem  [DIV_STAGES];
  logic [22:0] dsr  [DIV_STAGES];
  logic [15:0] qacc [DIV_STAGES];
  logic [23:0] st   [DIV_STAGES];

  function automatic logic [23:0] div_step(input logic [22:0] r, input logic [22:0] d);
    logic [23:0] r2;
    logic [23:0] diff;
    begin
      r2   = {r, 1'b0};
      diff = r2 - {1'b0, d};
      // Bit 23 carries the quotient bit, the low bits the next remainder.
      if (r2 >= {1'b0, d}) begin
        div_step = {1'b1, diff[22:0]};
      end else begin
        div_step = {1'b0, r2[22:0]};
      end
    end
  endfunction

  always_comb begin
    st[0] = div_step(num, den);
    for (int k = 1; k < DIV_STAGES; k++) begin
      st[k] = div_step(rem[k-1], dsr[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= st[0][22:0];
      dsr[0]  <= den;
      qacc[0] <= {15'd0, st[0][23]};
      for (int k = 1; k < DIV_STAGES; k++) begin
        rem[k]  <= st[k][22:0];
        dsr[k]  <= dsr[k-1];
        qacc[k] <= {qacc[k-1][14:0], st[k][23]};
      end
    end
  end

  assign quo = qacc[DIV_STAGES-1];

endmodule

FILE: hw/rtl/pst_blend.sv
// Two-stage color blend: channel products, then sum and truncation to 8 bits.
// Depends on pst_pkg.
module pst_blend
  import pst_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] start_color,
  input  logic [31:0] end_color,
  input  logic [15:0] t16,
  output logic [7:0]  chan [4]
);

  logic [24:0] ps [4];
  logic [23:0] pe [4];
  logic [16:0] inv_t;
  logic [24:0] sum [4];

  assign inv_t = 17'h1_0000 - {1'b0, t16};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sum[c] = ps[c] + {1'b0, pe[c]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Channel 0 is red, in the top byte.
      for (int c = 0; c < 4; c++) begin
        ps[c]   <= {8'd0, start_color[8*(3-c) +: 8]} * {8'd0, inv_t};
        pe[c]   <= {8'd0, end_color[8*(3-c) +: 8]} * {8'd0, t16};
        chan[c] <= sum[c][23:16];
      end
    end
  end

endmodule

FILE: hw/rtl/particle_state_update.sv
// Particle state update: registered pipeline from an accepted word to its result word.
// Throughput one word per cycle unless the output stalls; the depth is set by the
// 16-stage blend factor divider plus one setup stage and two blend stages. Dead or
// expiring particles leave a bubble. A stalled output freezes the whole pipeline.
// Synchronous reset clears the valid bits and loads the register defaults.
module particle_state_update
  import pst_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 src_valid,
  output logic                 src_stall,
  input  in_word_t             src_data,
  output logic                 dst_valid,
  input  logic                 dst_stall,
  output out_word_t            dst_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int VLD_LEN = DIV_STAGES + 3;
  localparam int DLY_LEN = VLD_LEN - 5;

  logic [31:0] gravity_x, gravity_y, gravity_z, start_color, end_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_x   <= GRAVITY_X_RST;
      gravity_y   <= GRAVITY_Y_RST;
      gravity_z   <= GRAVITY_Z_RST;
      start_color <= START_COLOR_RST;
      end_color   <= END_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRAVITY_X:   gravity_x   <= cfg_data;
        REG_GRAVITY_Y:   gravity_y   <= cfg_data;
        REG_GRAVITY_Z:   gravity_z   <= cfg_data;
        REG_START_COLOR: start_color <= cfg_data;
        REG_END_COLOR:   end_color   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !(dst_valid && dst_stall);
  assign src_stall = !en;

  // Setup stage: life check and divider operands.
  logic signed [24:0] nlife_w;
  logic [22:0]        nlife;
  logic               alive;
  logic               t_zero;

  assign nlife_w = {src_data.life_left[23], src_data.life_left} - {9'd0, src_data.time_step};
  assign nlife   = nlife_w[22:0];
  assign alive   = !src_data.life_left[23] && (src_data.life_left != 24'sd0)
                   && !nlife_w[24] && (nlife_w != 25'sd0);
  assign t_zero  = (src_data.life_total == 23'd0) || (nlife >= src_data.life_total);

  in_word_t     prep_rec;
  logic [22:0]  prep_life;
  logic [22:0]  prep_num;
  logic [22:0]  prep_den;
  logic [VLD_LEN-1:0] vld;

  always_ff @(posedge clk) begin
    if (en) begin
      prep_rec  <= src_data;
      prep_life <= nlife;
      prep_num  <= t_zero ? 23'd0 : (src_data.life_total - nlife);
      prep_den  <= t_zero ? 23'd1 : src_data.life_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[VLD_LEN-2:0], src_valid && alive};
    end
  end

  motion_t     mres;
  logic [15:0] t16;
  logic [7:0]  chan [4];

  pst_motion u_motion (
    .clk       (clk),
    .en        (en),
    .gravity_x (gravity_x),
    .gravity_y (gravity_y),
    .gravity_z (gravity_z),
    .rec       (prep_rec),
    .life      (prep_life),
    .res       (mres)
  );

  pst_div u_div (
    .clk (clk),
    .en  (en),
    .num (prep_num),
    .den (prep_den),
    .quo (t16)
  );

  pst_blend u_blend (
    .clk         (clk),
    .en          (en),
    .start_color (start_color),
    .end_color   (end_color),
    .t16         (t16),
    .chan        (chan)
  );

  // Holds motion results until the blend factor of the same word is ready.
  motion_t dly [DLY_LEN];

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= mres;
      for (int k = 1; k < DLY_LEN; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  assign dst_valid = vld[VLD_LEN-1];

  always_comb begin
    dst_data.new_pos_x      = dly[DLY_LEN-1].pos_x;
    dst_data.new_pos_y      = dly[DLY_LEN-1].pos_y;
    dst_data.new_pos_z      = dly[DLY_LEN-1].pos_z;
    dst_data.new_vel_x      = dly[DLY_LEN-1].vel_x;
    dst_data.new_vel_y      = dly[DLY_LEN-1].vel_y;
    dst_data.new_vel_z      = dly[DLY_LEN-1].vel_z;
    dst_data.new_spin_angle = dly[DLY_LEN-1].angle;
    dst_data.new_life_left  = dly[DLY_LEN-1].life;
    dst_data.color_red      = chan[0];
    dst_data.color_green    = chan[1];
    dst_data.color_blue     = chan[2];
    dst_data.color_alpha    = chan[3];
  end

endmodule
